/* sv/mnsub_pkg.sv */
// Mixed number subtractor: shared types, constants and helper functions.
// No dependencies; used by every module of the block.
package mnsub_pkg;

    localparam int CALC_W      = 64;
    localparam int CNT_W       = $clog2(CALC_W);
    localparam int IN_WIDTH_DEF = 16;
    localparam int WHOLE_W     = 18;
    localparam int NUM_W       = 30;
    localparam int DEN_W       = 31;

    typedef logic [CALC_W-1:0] word_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_GCD
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_GCD_DEN,
        ST_DIV_Q,
        ST_MUL_LCM,
        ST_DIV_FA,
        ST_DIV_FB,
        ST_MUL_WA,
        ST_MUL_WB,
        ST_MUL_TA,
        ST_MUL_TB,
        ST_GCD_RED,
        ST_DIV_RN,
        ST_DIV_RD,
        ST_DIV_WHOLE
    } step_t;

    typedef struct packed {
        logic  load_in;
        logic  start;
        logic  writeback;
        logic  load_out;
        step_t step;
    } dp_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic alu_done;
    } dp_stat_t;

    function automatic alu_op_t step_op(step_t s);
        alu_op_t op;
        case (s)
            ST_GCD_DEN, ST_GCD_RED:                        op = OP_GCD;
            ST_MUL_LCM, ST_MUL_WA, ST_MUL_WB,
            ST_MUL_TA, ST_MUL_TB:                          op = OP_MUL;
            default:                                       op = OP_DIV;
        endcase
        return op;
    endfunction

    function automatic word_t mag(word_t v);
        return v[CALC_W-1] ? (~v + word_t'(1)) : v;
    endfunction

endpackage

/* sv/mixed_number_subtractor_top.sv */
// Mixed number subtractor, top level: controller plus datapath.
// Depends on mnsub_pkg, mnsub_ctrl, mnsub_datapath.
//
// Input channel (in_valid/in_ready) carries two mixed numbers A and B; the
// output channel (out_valid/out_ready) carries A - B as reduced whole part,
// numerator and positive denominator, plus negative and div_error flags.
// One item is worked at a time; in_ready is high only while the block is idle.
// Each item runs thirteen steps on one shared 64-bit iterative unit: five
// multiplies, six divides and two binary GCDs that shift or subtract.
// A zero denominator skips the arithmetic: the controller goes from the
// issue state straight to the finish state, and out_valid rises once the
// output register is free.
// The result sits in an output register; a new item is accepted while it
// waits, but the next result is held in the datapath until out_ready frees
// the output register. Reset clears the controller; no result is pending.
module mixed_number_subtractor_top #(
    parameter int IN_WIDTH = mnsub_pkg::IN_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [IN_WIDTH-1:0]    whole_a,
    input  logic        [IN_WIDTH-2:0]    num_a,
    input  logic signed [IN_WIDTH-1:0]    den_a,
    input  logic signed [IN_WIDTH-1:0]    whole_b,
    input  logic        [IN_WIDTH-2:0]    num_b,
    input  logic signed [IN_WIDTH-1:0]    den_b,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [mnsub_pkg::WHOLE_W-1:0] diff_whole,
    output logic        [mnsub_pkg::NUM_W-1:0]   diff_num,
    output logic        [mnsub_pkg::DEN_W-1:0]   diff_den,
    output logic                          negative,
    output logic                          div_error
);
    import mnsub_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mnsub_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mnsub_datapath #(
        .IN_WIDTH (IN_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .whole_a    (whole_a),
        .num_a      (num_a),
        .den_a      (den_a),
        .whole_b    (whole_b),
        .num_b      (num_b),
        .den_b      (den_b),
        .diff_whole (diff_whole),
        .diff_num   (diff_num),
        .diff_den   (diff_den),
        .negative   (negative),
        .div_error  (div_error)
    );

endmodule

/* sv/mnsub_alu.sv */
// Iterative 64-bit unit: shift-add multiply, restoring divide, binary GCD.
// One step per cycle. Depends on mnsub_pkg.
module mnsub_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mnsub_pkg::alu_op_t op,
    input  mnsub_pkg::word_t  x,
    input  mnsub_pkg::word_t  y,
    output logic              done,
    output mnsub_pkg::word_t  res_a,
    output mnsub_pkg::word_t  res_b
);
    import mnsub_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    alu_op_t           op_reg;
    word_t             a_reg;
    word_t             b_reg;
    word_t             acc_reg;
    word_t             rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [CALC_W:0]   trial;
    logic [CALC_W:0]   trial_sub;
    logic              fin;

    always_comb
    begin
        trial     = {rem_reg, a_reg[CALC_W-1]};
        trial_sub = trial - {1'b0, b_reg};
        if (op_reg == OP_GCD)
            fin = (a_reg == '0) || (b_reg == '0);
        else
            fin = (cnt_reg == CNT_W'(CALC_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && fin)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= op;
            a_reg   <= x;
            b_reg   <= y;
            acc_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
            k_reg   <= '0;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    if (b_reg[0])
                        acc_reg <= acc_reg + a_reg;
                    a_reg   <= a_reg << 1;
                    b_reg   <= b_reg >> 1;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                OP_DIV:
                begin
                    if (!trial_sub[CALC_W])
                    begin
                        rem_reg <= trial_sub[CALC_W-1:0];
                        a_reg   <= {a_reg[CALC_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[CALC_W-1:0];
                        a_reg   <= {a_reg[CALC_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                OP_GCD:
                begin
                    if (a_reg == '0)
                        acc_reg <= b_reg << k_reg;
                    else if (b_reg == '0)
                        acc_reg <= a_reg << k_reg;
                    else if (!a_reg[0] && !b_reg[0])
                    begin
                        a_reg <= a_reg >> 1;
                        b_reg <= b_reg >> 1;
                        k_reg <= k_reg + CNT_W'(1);
                    end
                    else if (!a_reg[0])
                        a_reg <= a_reg >> 1;
                    else if (!b_reg[0])
                        b_reg <= b_reg >> 1;
                    else if (a_reg >= b_reg)
                        a_reg <= a_reg - b_reg;
                    else
                        b_reg <= b_reg - a_reg;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign res_a = (op_reg == OP_DIV) ? a_reg : acc_reg;
    assign res_b = rem_reg;

endmodule

/* sv/mnsub_datapath.sv */
// Datapath: operand and intermediate registers, the iterative unit, result registers.
// Depends on mnsub_pkg and mnsub_alu.
module mnsub_datapath #(
    parameter int IN_WIDTH = mnsub_pkg::IN_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mnsub_pkg::dp_cmd_t            cmd,
    output mnsub_pkg::dp_stat_t           stat,
    input  logic signed [IN_WIDTH-1:0]    whole_a,
    input  logic        [IN_WIDTH-2:0]    num_a,
    input  logic signed [IN_WIDTH-1:0]    den_a,
    input  logic signed [IN_WIDTH-1:0]    whole_b,
    input  logic        [IN_WIDTH-2:0]    num_b,
    input  logic signed [IN_WIDTH-1:0]    den_b,
    output logic signed [mnsub_pkg::WHOLE_W-1:0] diff_whole,
    output logic        [mnsub_pkg::NUM_W-1:0]   diff_num,
    output logic        [mnsub_pkg::DEN_W-1:0]   diff_den,
    output logic                          negative,
    output logic                          div_error
);
    import mnsub_pkg::*;

    word_t wa_reg, na_reg, da_reg, wb_reg, nb_reg, db_reg;
    word_t g_reg, lcm_reg, fa_reg, fb_reg, pa_reg, pb_reg, t_reg;
    word_t r_reg, rn_reg, rd_reg, whole_reg, rem_reg;
    word_t op_x, op_y, res_a, res_b, signed_whole;
    logic  alu_done, neg;

    logic signed [WHOLE_W-1:0] diff_whole_reg;
    logic [NUM_W-1:0]          diff_num_reg;
    logic [DEN_W-1:0]          diff_den_reg;
    logic                      negative_reg;
    logic                      div_error_reg;

    always_comb
    begin
        op_x = '0;
        op_y = '0;
        case (cmd.step)
            ST_GCD_DEN:   begin op_x = mag(da_reg);  op_y = mag(db_reg); end
            ST_DIV_Q:     begin op_x = mag(da_reg);  op_y = g_reg;       end
            ST_MUL_LCM:   begin op_x = g_reg;        op_y = mag(db_reg); end
            ST_DIV_FA:    begin op_x = lcm_reg;      op_y = mag(da_reg); end
            ST_DIV_FB:    begin op_x = lcm_reg;      op_y = mag(db_reg); end
            ST_MUL_WA:    begin op_x = wa_reg;       op_y = da_reg;      end
            ST_MUL_WB:    begin op_x = wb_reg;       op_y = db_reg;      end
            ST_MUL_TA:    begin op_x = pa_reg;       op_y = fa_reg;      end
            ST_MUL_TB:    begin op_x = pb_reg;       op_y = fb_reg;      end
            ST_GCD_RED:   begin op_x = mag(t_reg);   op_y = lcm_reg;     end
            ST_DIV_RN:    begin op_x = mag(t_reg);   op_y = r_reg;       end
            ST_DIV_RD:    begin op_x = lcm_reg;      op_y = r_reg;       end
            ST_DIV_WHOLE: begin op_x = rn_reg;       op_y = rd_reg;      end
            default:      begin op_x = '0;           op_y = '0;          end
        endcase
    end

    mnsub_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start),
        .op    (step_op(cmd.step)),
        .x     (op_x),
        .y     (op_y),
        .done  (alu_done),
        .res_a (res_a),
        .res_b (res_b)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            wa_reg <= CALC_W'(signed'(whole_a));
            na_reg <= CALC_W'(num_a);
            da_reg <= CALC_W'(signed'(den_a));
            wb_reg <= CALC_W'(signed'(whole_b));
            nb_reg <= CALC_W'(num_b);
            db_reg <= CALC_W'(signed'(den_b));
        end
        if (cmd.writeback)
        begin
            case (cmd.step)
                ST_GCD_DEN:   g_reg   <= res_a;
                ST_DIV_Q:     g_reg   <= res_a;
                ST_MUL_LCM:   lcm_reg <= (res_a == '0) ? word_t'(1) : res_a;
                ST_DIV_FA:    fa_reg  <= da_reg[CALC_W-1] ? (~res_a + word_t'(1)) : res_a;
                ST_DIV_FB:    fb_reg  <= db_reg[CALC_W-1] ? (~res_a + word_t'(1)) : res_a;
                ST_MUL_WA:    pa_reg  <= wa_reg[CALC_W-1] ? (res_a - na_reg) : (res_a + na_reg);
                ST_MUL_WB:    pb_reg  <= wb_reg[CALC_W-1] ? (res_a - nb_reg) : (res_a + nb_reg);
                ST_MUL_TA:    t_reg   <= res_a;
                ST_MUL_TB:    t_reg   <= t_reg - res_a;
                ST_GCD_RED:   r_reg   <= (res_a == '0) ? word_t'(1) : res_a;
                ST_DIV_RN:    rn_reg  <= res_a;
                ST_DIV_RD:    rd_reg  <= (res_a == '0) ? word_t'(1) : res_a;
                ST_DIV_WHOLE:
                begin
                    whole_reg <= res_a;
                    rem_reg   <= res_b;
                end
                default:      g_reg   <= g_reg;
            endcase
        end
    end

    always_comb
    begin
        neg          = t_reg[CALC_W-1] && (rn_reg != '0);
        signed_whole = neg ? (~whole_reg + word_t'(1)) : whole_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (stat.den_zero)
            begin
                diff_whole_reg <= '0;
                diff_num_reg   <= '0;
                diff_den_reg   <= '0;
                negative_reg   <= 1'b0;
                div_error_reg  <= 1'b1;
            end
            else
            begin
                diff_whole_reg <= signed_whole[WHOLE_W-1:0];
                diff_num_reg   <= rem_reg[NUM_W-1:0];
                diff_den_reg   <= rd_reg[DEN_W-1:0];
                negative_reg   <= neg;
                div_error_reg  <= 1'b0;
            end
        end
    end

    assign stat.den_zero = (da_reg == '0) || (db_reg == '0);
    assign stat.alu_done = alu_done;

    assign diff_whole = diff_whole_reg;
    assign diff_num   = diff_num_reg;
    assign diff_den   = diff_den_reg;
    assign negative   = negative_reg;
    assign div_error  = div_error_reg;

endmodule

/* sv/mnsub_ctrl.sv */
// Controller: sequences the datapath steps and runs both handshakes.
// Depends on mnsub_pkg.
module mnsub_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  mnsub_pkg::dp_stat_t stat,
    output mnsub_pkg::dp_cmd_t  cmd
);
    import mnsub_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.step       = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    step_next   = ST_GCD_DEN;
                    state_next  = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (stat.den_zero)
                    state_next = S_FINISH;
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (stat.alu_done)
                begin
                    cmd.writeback = 1'b1;
                    if (step_reg == ST_DIV_WHOLE)
                        state_next = S_FINISH;
                    else
                    begin
                        step_next  = step_t'(step_reg + 4'd1);
                        state_next = S_ISSUE;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_GCD_DEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* sv/mnsub_checker.sv */
// Port-level checks for the mixed number subtractor, bound to the top level.
// Depends on mnsub_pkg.
module mnsub_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [mnsub_pkg::WHOLE_W-1:0] diff_whole,
    input logic        [mnsub_pkg::NUM_W-1:0]   diff_num,
    input logic        [mnsub_pkg::DEN_W-1:0]   diff_den,
    input logic                                 negative,
    input logic                                 div_error
);
    import mnsub_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(diff_whole)
            && $stable(diff_num) && $stable(diff_den) && $stable(negative)
            && $stable(div_error))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_error |-> diff_whole == '0 && diff_num == '0
            && diff_den == '0 && !negative)
        else $error("error result not cleared");

    a_proper: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !div_error |-> diff_den != '0
            && DEN_W'(diff_num) < diff_den)
        else $error("remainder not below denominator");

    a_zero_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && diff_whole == '0 && diff_num == '0 |-> !negative)
        else $error("zero result marked negative");

endmodule

bind mixed_number_subtractor_top mnsub_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .diff_whole (diff_whole),
    .diff_num   (diff_num),
    .diff_den   (diff_den),
    .negative   (negative),
    .div_error  (div_error)
);

/* tb/tb_mixed_number_subtractor_top.sv */
// Testbench for mixed_number_subtractor_top: directed and random mixed-number pairs,
// predicted in 64-bit arithmetic and checked by a small scoreboard class.
// Depends on mnsub_pkg and the block's RTL.
module tb_mixed_number_subtractor_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mnsub_pkg::*;

    typedef struct packed {
        logic signed [WHOLE_W-1:0] whole;
        logic [NUM_W-1:0]          num;
        logic [DEN_W-1:0]          den;
        logic                      neg;
        logic                      err;
    } diff_t;

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic logic [63:0] abs64(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic diff_t subtract_mixed(logic signed [15:0] wa, logic [14:0] na,
                                             logic signed [15:0] da, logic signed [15:0] wb,
                                             logic [14:0] nb, logic signed [15:0] db);
        diff_t d;
        logic [63:0] xwa, xda, xwb, xdb, ma, mb, l, fa, fb, pa, pb, t, tm, r, rn, rd, q;
        d = '0;
        if (da == 0 || db == 0)
        begin
            d.err = 1'b1;
            return d;
        end
        xwa = 64'(wa); xda = 64'(da); xwb = 64'(wb); xdb = 64'(db);
        ma = abs64(xda);
        mb = abs64(xdb);
        l = (ma / gcd64(ma, mb)) * mb;
        if (l == 0) l = 1;
        fa = l / ma;
        fb = l / mb;
        if (xda[63]) fa = -fa;
        if (xdb[63]) fb = -fb;
        pa = xwa[63] ? xwa * xda - 64'(na) : xwa * xda + 64'(na);
        pb = xwb[63] ? xwb * xdb - 64'(nb) : xwb * xdb + 64'(nb);
        t = pa * fa - pb * fb;
        tm = abs64(t);
        r = gcd64(tm, l);
        if (r == 0) r = 1;
        rn = tm / r;
        rd = l / r;
        if (rd == 0) rd = 1;
        q = rn / rd;
        d.neg = t[63] && rn != 0;
        d.whole = d.neg ? WHOLE_W'(-q) : WHOLE_W'(q);
        d.num = NUM_W'(rn % rd);
        d.den = DEN_W'(rd);
        return d;
    endfunction

    class diff_scoreboard;
        diff_t pending[$];
        int    errors;
        int    checked;

        function void note_item(diff_t d);
            pending.push_back(d);
        endfunction

        function void check_result(diff_t got);
            diff_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result item");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.whole !== e.whole)
            begin
                $error("diff_whole exp %0d got %0d", e.whole, got.whole); errors++;
            end
            if (got.num !== e.num)
            begin
                $error("diff_num exp %0d got %0d", e.num, got.num); errors++;
            end
            if (got.den !== e.den)
            begin
                $error("diff_den exp %0d got %0d", e.den, got.den); errors++;
            end
            if (got.neg !== e.neg)
            begin
                $error("negative exp %0b got %0b", e.neg, got.neg); errors++;
            end
            if (got.err !== e.err)
            begin
                $error("div_error exp %0b got %0b", e.err, got.err); errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] whole_a = '0, den_a = 16'sd1, whole_b = '0, den_b = 16'sd1;
    logic [14:0] num_a = '0, num_b = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [WHOLE_W-1:0] diff_whole;
    logic [NUM_W-1:0] diff_num;
    logic [DEN_W-1:0] diff_den;
    logic negative, div_error;

    diff_scoreboard sb = new();
    int n_sent = 0;
    int n_err_items = 0;

    mixed_number_subtractor_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .whole_a(whole_a), .num_a(num_a), .den_a(den_a),
        .whole_b(whole_b), .num_b(num_b), .den_b(den_b),
        .out_valid(out_valid), .out_ready(out_ready),
        .diff_whole(diff_whole), .diff_num(diff_num), .diff_den(diff_den),
        .negative(negative), .div_error(div_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
    endfunction

    task automatic send_item(logic signed [15:0] wa, logic [14:0] na, logic signed [15:0] da,
                             logic signed [15:0] wb, logic [14:0] nb, logic signed [15:0] db);
        int g;
        g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        whole_a <= wa; num_a <= na; den_a <= da;
        whole_b <= wb; num_b <= nb; den_b <= db;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_item(subtract_mixed(wa, na, da, wb, nb, db));
        if (da == 0 || db == 0) n_err_items++;
        n_sent++;
    endtask

    function automatic logic [15:0] rand_den();
        case ($urandom_range(0, 9))
            0: return 16'h0;
            1, 2: return 16'($urandom);
            default: return 16'($signed($urandom_range(1, 40)) * ($urandom_range(0, 1) ? -1 : 1));
        endcase
    endfunction

    function automatic logic [15:0] rand_whole();
        return $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 20)) - 10);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{diff_whole, diff_num, diff_den, negative, div_error});
    end

    initial
    begin
        int hold;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                hold = gap_len();
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        int wait_cnt;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(16'sd3, 15'd1, 16'sd2, 16'sd1, 15'd1, 16'sd3);
        send_item(16'sd2, 15'd1, 16'sd2, 16'sd2, 15'd1, 16'sd2);
        send_item(16'sd0, 15'd1, 16'sd2, 16'sd0, 15'd3, 16'sd4);
        send_item(-16'sd1, 15'd1, 16'sd2, 16'sd0, 15'd0, 16'sd1);
        send_item(16'sd1, 15'd0, 16'sd0, 16'sd1, 15'd1, 16'sd3);
        send_item(16'sd1, 15'd1, 16'sd3, 16'sd1, 15'd1, 16'sd0);
        send_item(16'sd5, 15'd2, -16'sd3, 16'sd1, 15'd1, 16'sd7);
        send_item(16'h7fff, 15'h7fff, 16'h7fff, 16'h8000, 15'h7fff, 16'h8000);
        send_item(16'h8000, 15'h7fff, 16'h8000, 16'h7fff, 15'h7fff, 16'h7fff);
        send_item(16'h8000, 15'h7fff, 16'h7fff, 16'h7fff, 15'h7fff, 16'h7ffe);
        send_item(16'h7fff, 15'h7fff, 16'sd1, 16'h8000, 15'h7fff, 16'sd1);
        send_item(16'h8000, 15'h0, 16'h8000, 16'h8000, 15'h0, 16'h8000);
        send_item(16'sd0, 15'h7fff, -16'sd1, 16'sd0, 15'h0, -16'sd1);
        send_item(16'h5555, 15'h2aaa, 16'h5555, 16'haaaa, 15'h5555, 16'haaaa);
        in_valid <= 1'b0;

        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < 100000)
        begin
            @(posedge clk);
            wait_cnt++;
        end

        repeat (1300)
        begin
            send_item(rand_whole(), ($urandom_range(0, 2) == 0) ? 15'($urandom) : 15'($urandom_range(0, 40)),
                      rand_den(), rand_whole(),
                      ($urandom_range(0, 2) == 0) ? 15'($urandom) : 15'($urandom_range(0, 40)),
                      rand_den());
        end
        in_valid <= 1'b0;

        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (1500) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("Ran %0d items (%0d with a zero denominator), %0d results checked.",
                 n_sent, n_err_items, sb.checked);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
